[rtl/core/adrc_pkg.sv]
// -----------------------------------------------------------------------------
// adrc_pkg: shared types, constants and helpers
// Register map, sequencer command bundle and the saturation helpers used by
// the first-order ADRC speed controller.
// -----------------------------------------------------------------------------
package adrc_pkg;

	localparam int SIG_W   = 32;   // Q16.16 signal width
	localparam int FRAC    = 24;   // coefficient fraction bits
	localparam int COEF_W  = 33;   // signed coefficient operand
	localparam int PROD_W  = SIG_W + COEF_W;
	localparam int RND_W   = PROD_W - FRAC;
	localparam int ACC_W   = 44;
	localparam int B2_W    = 28;   // beta squared, non-negative
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int BETA_W  = 25;
	localparam int GAIN_W  = 31;

	localparam logic signed [COEF_W-1:0] COEF_ONE   = COEF_W'(1) <<< FRAC;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC - 1);

	localparam logic [2:0] REG_BETA     = 3'd0;
	localparam logic [2:0] REG_STEP_H   = 3'd1;
	localparam logic [2:0] REG_PLANT    = 3'd2;
	localparam logic [2:0] REG_INV      = 3'd3;
	localparam logic [2:0] REG_OBS_GAIN = 3'd4;
	localparam logic [2:0] REG_CTRL_BW  = 3'd5;
	localparam logic [2:0] REG_LIMIT    = 3'd6;

	typedef struct packed {
		logic        [BETA_W-1:0] beta;
		logic        [BETA_W-1:0] step_h;
		logic signed [SIG_W-1:0]  plant_gain;
		logic signed [SIG_W-1:0]  inv_plant_gain;
		logic        [GAIN_W-1:0] observer_gain;
		logic        [GAIN_W-1:0] ctrl_bandwidth;
		logic        [GAIN_W-1:0] out_limit;
	} cfg_t;

	// multiplier operand pairs
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_PLANT_H,
		MUL_BETA_SQ,
		MUL_Z0_C1,
		MUL_Z1_H,
		MUL_W_C2,
		MUL_U_BH,
		MUL_E_G,
		MUL_Z0_B2,
		MUL_W_B2M,
		MUL_V_KP,
		MUL_V_INV
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB,
		ACC_LOAD_Y1
	} acc_op_t;

	// which intermediate is latched this cycle
	typedef enum logic [3:0] {
		LAT_NONE,
		LAT_BH,
		LAT_B2,
		LAT_Z0,
		LAT_GT,
		LAT_Z1,
		LAT_Y1,
		LAT_V0,
		LAT_V1,
		LAT_U
	} lat_t;

	typedef struct packed {
		logic     ld_in;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		lat_t     lat;
	} cmd_t;

	function automatic logic signed [ACC_W-1:0] ext_sig(input logic signed [SIG_W-1:0] x);
		return {{(ACC_W-SIG_W){x[SIG_W-1]}}, x};
	endfunction

	function automatic logic signed [ACC_W-1:0] ext_rnd(input logic signed [RND_W-1:0] x);
		return {{(ACC_W-RND_W){x[RND_W-1]}}, x};
	endfunction

	function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = {{(ACC_W-SIG_W+1){1'b0}}, {(SIG_W-1){1'b1}}};
		lo = ~hi;
		if (x > hi)
			return hi[SIG_W-1:0];
		else if (x < lo)
			return lo[SIG_W-1:0];
		else
			return x[SIG_W-1:0];
	endfunction

endpackage

[rtl/core/adrc_regs.sv]
// -----------------------------------------------------------------------------
// adrc_regs: configuration register file
// APB-style write/read access to the observer and controller coefficients.
// -----------------------------------------------------------------------------
module adrc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [adrc_pkg::ADDR_W-1:0]  paddr,
	input  logic [adrc_pkg::DATA_W-1:0]  pwdata,
	output logic [adrc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output adrc_pkg::cfg_t               cfg
);

	adrc_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[adrc_pkg::ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.beta           <= adrc_pkg::BETA_W'(15099494);
			cfg_q.step_h         <= adrc_pkg::BETA_W'(16777);
			cfg_q.plant_gain     <= adrc_pkg::SIG_W'(16777216);
			cfg_q.inv_plant_gain <= adrc_pkg::SIG_W'(16777216);
			cfg_q.observer_gain  <= adrc_pkg::GAIN_W'(167772160);
			cfg_q.ctrl_bandwidth <= adrc_pkg::GAIN_W'(167772160);
			cfg_q.out_limit      <= adrc_pkg::GAIN_W'(2147483647);
		end else if (wr_en) begin
			case (idx)
				adrc_pkg::REG_BETA:     cfg_q.beta           <= pwdata[adrc_pkg::BETA_W-1:0];
				adrc_pkg::REG_STEP_H:   cfg_q.step_h         <= pwdata[adrc_pkg::BETA_W-1:0];
				adrc_pkg::REG_PLANT:    cfg_q.plant_gain     <= $signed(pwdata);
				adrc_pkg::REG_INV:      cfg_q.inv_plant_gain <= $signed(pwdata);
				adrc_pkg::REG_OBS_GAIN: cfg_q.observer_gain  <= pwdata[adrc_pkg::GAIN_W-1:0];
				adrc_pkg::REG_CTRL_BW:  cfg_q.ctrl_bandwidth <= pwdata[adrc_pkg::GAIN_W-1:0];
				adrc_pkg::REG_LIMIT:    cfg_q.out_limit      <= pwdata[adrc_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			adrc_pkg::REG_BETA:     prdata = adrc_pkg::DATA_W'(cfg_q.beta);
			adrc_pkg::REG_STEP_H:   prdata = adrc_pkg::DATA_W'(cfg_q.step_h);
			adrc_pkg::REG_PLANT:    prdata = cfg_q.plant_gain;
			adrc_pkg::REG_INV:      prdata = cfg_q.inv_plant_gain;
			adrc_pkg::REG_OBS_GAIN: prdata = adrc_pkg::DATA_W'(cfg_q.observer_gain);
			adrc_pkg::REG_CTRL_BW:  prdata = adrc_pkg::DATA_W'(cfg_q.ctrl_bandwidth);
			adrc_pkg::REG_LIMIT:    prdata = adrc_pkg::DATA_W'(cfg_q.out_limit);
			default:                prdata = '0;
		endcase
	end

endmodule

[rtl/core/adrc_ctrl.sv]
// -----------------------------------------------------------------------------
// adrc_ctrl: sample sequencer
// One-hot state machine that steps the shared multiplier and accumulator
// through the observer and drive calculation, and owns the handshakes.
// -----------------------------------------------------------------------------
module adrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output adrc_pkg::cmd_t    cmd
);

	typedef enum logic [18:0] {
		ST_IDLE = 19'h00001,
		ST_BH   = 19'h00002,
		ST_B2   = 19'h00004,
		ST_Z0A  = 19'h00008,
		ST_Z0B  = 19'h00010,
		ST_Z0C  = 19'h00020,
		ST_Z0D  = 19'h00040,
		ST_Z0E  = 19'h00080,
		ST_Z0   = 19'h00100,
		ST_GT   = 19'h00200,
		ST_Y0A  = 19'h00400,
		ST_Y0B  = 19'h00800,
		ST_Y0C  = 19'h01000,
		ST_V0   = 19'h02000,
		ST_KP   = 19'h04000,
		ST_KPB  = 19'h08000,
		ST_V1   = 19'h10000,
		ST_INV  = 19'h20000,
		ST_U    = 19'h40000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '{ld_in: 1'b0, mul_sel: adrc_pkg::MUL_NONE,
		                acc_op: adrc_pkg::ACC_HOLD, lat: adrc_pkg::LAT_NONE};
		state_nxt   = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_nxt = ST_BH;
				end
			end
			ST_BH: begin
				cmd.mul_sel = adrc_pkg::MUL_PLANT_H;
				state_nxt   = ST_B2;
			end
			ST_B2: begin
				cmd.lat     = adrc_pkg::LAT_BH;
				cmd.mul_sel = adrc_pkg::MUL_BETA_SQ;
				state_nxt   = ST_Z0A;
			end
			ST_Z0A: begin
				cmd.lat     = adrc_pkg::LAT_B2;
				cmd.mul_sel = adrc_pkg::MUL_Z0_C1;
				state_nxt   = ST_Z0B;
			end
			ST_Z0B: begin
				cmd.acc_op  = adrc_pkg::ACC_LOAD;
				cmd.mul_sel = adrc_pkg::MUL_Z1_H;
				state_nxt   = ST_Z0C;
			end
			ST_Z0C: begin
				cmd.acc_op  = adrc_pkg::ACC_ADD;
				cmd.mul_sel = adrc_pkg::MUL_W_C2;
				state_nxt   = ST_Z0D;
			end
			ST_Z0D: begin
				cmd.acc_op  = adrc_pkg::ACC_SUB;
				cmd.mul_sel = adrc_pkg::MUL_U_BH;
				state_nxt   = ST_Z0E;
			end
			ST_Z0E: begin
				cmd.acc_op = adrc_pkg::ACC_ADD;
				state_nxt  = ST_Z0;
			end
			ST_Z0: begin
				cmd.lat   = adrc_pkg::LAT_Z0;
				state_nxt = ST_GT;
			end
			ST_GT: begin
				cmd.mul_sel = adrc_pkg::MUL_E_G;
				state_nxt   = ST_Y0A;
			end
			ST_Y0A: begin
				cmd.lat     = adrc_pkg::LAT_GT;
				cmd.mul_sel = adrc_pkg::MUL_Z0_B2;
				state_nxt   = ST_Y0B;
			end
			ST_Y0B: begin
				cmd.lat     = adrc_pkg::LAT_Z1;
				cmd.acc_op  = adrc_pkg::ACC_LOAD;
				cmd.mul_sel = adrc_pkg::MUL_W_B2M;
				state_nxt   = ST_Y0C;
			end
			ST_Y0C: begin
				cmd.lat    = adrc_pkg::LAT_Y1;
				cmd.acc_op = adrc_pkg::ACC_SUB;
				state_nxt  = ST_V0;
			end
			ST_V0: begin
				cmd.lat   = adrc_pkg::LAT_V0;
				state_nxt = ST_KP;
			end
			ST_KP: begin
				cmd.mul_sel = adrc_pkg::MUL_V_KP;
				state_nxt   = ST_KPB;
			end
			ST_KPB: begin
				cmd.acc_op = adrc_pkg::ACC_LOAD_Y1;
				state_nxt  = ST_V1;
			end
			ST_V1: begin
				cmd.lat   = adrc_pkg::LAT_V1;
				state_nxt = ST_INV;
			end
			ST_INV: begin
				cmd.mul_sel = adrc_pkg::MUL_V_INV;
				state_nxt   = ST_U;
			end
			ST_U: begin
				// product stays in the multiplier register until the output slot frees
				if (out_free) begin
					cmd.lat   = adrc_pkg::LAT_U;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.lat == adrc_pkg::LAT_U)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/adrc_dp.sv]
// -----------------------------------------------------------------------------
// adrc_dp: observer and drive datapath
// Shared signed multiplier with rounding, saturating accumulator, observer
// state and the clamped drive register.
// -----------------------------------------------------------------------------
module adrc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  adrc_pkg::cfg_t                     cfg,
	input  adrc_pkg::cmd_t                     cmd,
	input  logic signed [adrc_pkg::SIG_W-1:0]  speed_meas,
	input  logic signed [adrc_pkg::SIG_W-1:0]  speed_ref,
	output logic signed [adrc_pkg::SIG_W-1:0]  drive
);

	localparam int SW = adrc_pkg::SIG_W;
	localparam int CW = adrc_pkg::COEF_W;

	logic signed [SW-1:0]               w_q, ref_q;
	logic signed [SW-1:0]               est_output_q, est_disturbance_q, last_drive_q;
	logic signed [SW-1:0]               bh_q, e_q, y1_q, v_q;
	logic signed [adrc_pkg::B2_W-1:0]   b2_q;
	logic signed [adrc_pkg::RND_W-1:0]  gt_q;
	logic signed [adrc_pkg::PROD_W-1:0] prod_s1;
	logic signed [adrc_pkg::ACC_W-1:0]  acc_q;

	logic signed [SW-1:0]               op_a;
	logic signed [CW-1:0]               op_c;
	logic signed [CW-1:0]               beta_x2, b2_ext;
	logic signed [adrc_pkg::RND_W-1:0]  rnd;
	logic signed [SW-1:0]               acc_sat, z0_new, u_sat, lim, u_clamp;

	assign drive   = last_drive_q;
	assign beta_x2 = $signed({{(CW-adrc_pkg::BETA_W-1){1'b0}}, cfg.beta, 1'b0});
	assign b2_ext  = {{(CW-adrc_pkg::B2_W){b2_q[adrc_pkg::B2_W-1]}}, b2_q};
	// floor of the biased product is the round-half-up result
	assign rnd     = prod_s1[adrc_pkg::PROD_W-1:adrc_pkg::FRAC];
	assign acc_sat = adrc_pkg::sat_sig(acc_q);
	assign z0_new  = acc_sat;
	assign u_sat   = adrc_pkg::sat_sig(adrc_pkg::ext_rnd(rnd));
	assign lim     = $signed({1'b0, cfg.out_limit});

	always_comb begin
		if (u_sat > lim)
			u_clamp = lim;
		else if (u_sat < -lim)
			u_clamp = -lim;
		else
			u_clamp = u_sat;
	end

	always_comb begin
		op_a = '0;
		op_c = '0;
		case (cmd.mul_sel)
			adrc_pkg::MUL_PLANT_H: begin
				op_a = cfg.plant_gain;
				op_c = $signed(CW'(cfg.step_h));
			end
			adrc_pkg::MUL_BETA_SQ: begin
				op_a = $signed(SW'(cfg.beta));
				op_c = $signed(CW'(cfg.beta));
			end
			adrc_pkg::MUL_Z0_C1: begin
				op_a = est_output_q;
				op_c = beta_x2 - adrc_pkg::COEF_ONE;
			end
			adrc_pkg::MUL_Z1_H: begin
				op_a = est_disturbance_q;
				op_c = $signed(CW'(cfg.step_h));
			end
			adrc_pkg::MUL_W_C2: begin
				op_a = w_q;
				op_c = beta_x2 - (adrc_pkg::COEF_ONE <<< 1);
			end
			adrc_pkg::MUL_U_BH: begin
				op_a = last_drive_q;
				op_c = {bh_q[SW-1], bh_q};
			end
			adrc_pkg::MUL_E_G: begin
				op_a = e_q;
				op_c = $signed(CW'(cfg.observer_gain));
			end
			adrc_pkg::MUL_Z0_B2: begin
				op_a = est_output_q;
				op_c = b2_ext;
			end
			adrc_pkg::MUL_W_B2M: begin
				op_a = w_q;
				op_c = b2_ext - adrc_pkg::COEF_ONE;
			end
			adrc_pkg::MUL_V_KP: begin
				op_a = v_q;
				op_c = $signed(CW'(cfg.ctrl_bandwidth));
			end
			adrc_pkg::MUL_V_INV: begin
				op_a = v_q;
				op_c = {cfg.inv_plant_gain[SW-1], cfg.inv_plant_gain};
			end
			default: ;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			w_q   <= speed_meas;
			ref_q <= speed_ref;
		end
		if (cmd.mul_sel != adrc_pkg::MUL_NONE)
			prod_s1 <= adrc_pkg::PROD_W'(op_a) * adrc_pkg::PROD_W'(op_c) + adrc_pkg::ROUND_HALF;
		case (cmd.acc_op)
			adrc_pkg::ACC_LOAD:    acc_q <= adrc_pkg::ext_rnd(rnd);
			adrc_pkg::ACC_ADD:     acc_q <= acc_q + adrc_pkg::ext_rnd(rnd);
			adrc_pkg::ACC_SUB:     acc_q <= acc_q - adrc_pkg::ext_rnd(rnd);
			adrc_pkg::ACC_LOAD_Y1: acc_q <= adrc_pkg::ext_rnd(rnd) - adrc_pkg::ext_sig(y1_q);
			default: ;
		endcase
		case (cmd.lat)
			adrc_pkg::LAT_BH: bh_q <= adrc_pkg::sat_sig(adrc_pkg::ext_rnd(rnd));
			adrc_pkg::LAT_B2: b2_q <= rnd[adrc_pkg::B2_W-1:0];
			adrc_pkg::LAT_Z0: e_q  <= adrc_pkg::sat_sig(adrc_pkg::ext_sig(w_q)
			                          - adrc_pkg::ext_sig(z0_new));
			adrc_pkg::LAT_GT: gt_q <= rnd;
			adrc_pkg::LAT_Y1: y1_q <= adrc_pkg::sat_sig(adrc_pkg::ext_sig(est_disturbance_q)
			                          + adrc_pkg::ext_rnd(gt_q));
			adrc_pkg::LAT_V0: v_q  <= adrc_pkg::sat_sig(adrc_pkg::ext_sig(ref_q)
			                          - adrc_pkg::ext_sig(acc_sat));
			adrc_pkg::LAT_V1: v_q  <= acc_sat;
			default: ;
		endcase
	end

	// observer state and stored drive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_output_q      <= '0;
			est_disturbance_q <= '0;
			last_drive_q      <= '0;
		end else begin
			case (cmd.lat)
				adrc_pkg::LAT_Z0: est_output_q <= z0_new;
				adrc_pkg::LAT_Z1: est_disturbance_q <= adrc_pkg::sat_sig(
				                      adrc_pkg::ext_sig(est_disturbance_q)
				                      + adrc_pkg::ext_rnd(gt_q));
				adrc_pkg::LAT_U:  last_drive_q <= u_clamp;
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/adrc_first_order_speed_unit.sv]
// -----------------------------------------------------------------------------
// adrc_first_order_speed_unit: first-order linear ADRC speed controller
// Discrete extended state observer plus proportional drive law, one drive
// value per speed sample.
// -----------------------------------------------------------------------------
// One sample in, one drive out. A sample is taken in the idle state; the drive
// value is presented on the return to idle, where the next sample can be taken;
// it holds one sample at a time and waits in its last state while the output
// stalls. The pace is set by the single 32x33 rounding multiplier, which the
// sequencer steps through eleven products (b*h, beta^2, the four observer
// terms, g*e, the two output-estimate terms, kp and 1/b) plus the saturation
// steps between them. The drive register holds its value until it is taken; a
// new result waits in the multiplier register meanwhile. Coefficients are
// Q8.24, signals Q16.16; intermediates but g*e and beta^2 saturate to 32 bits;
// the drive is clamped to +/-out_limit. Configure only when idle.
module adrc_first_order_speed_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [adrc_pkg::ADDR_W-1:0]        paddr,
	input  logic [adrc_pkg::DATA_W-1:0]        pwdata,
	output logic [adrc_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [adrc_pkg::SIG_W-1:0]  speed_meas,
	input  logic signed [adrc_pkg::SIG_W-1:0]  speed_ref,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [adrc_pkg::SIG_W-1:0]  drive
);

	adrc_pkg::cfg_t cfg;
	adrc_pkg::cmd_t ctrl_cmd;

	adrc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	adrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (ctrl_cmd)
	);

	adrc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (ctrl_cmd),
		.speed_meas (speed_meas),
		.speed_ref  (speed_ref),
		.drive      (drive)
	);

`ifndef SYNTHESIS
	// a taken sample must close the input until its drive is latched
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a sample transfer");

	// a new drive never overwrites one still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_cmd.lat == adrc_pkg::LAT_U |-> !out_valid || !out_stall)
		else $error("drive latched while previous result pending");

	// output valid only rises from a drive latch
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctrl_cmd.lat == adrc_pkg::LAT_U))
		else $error("out_valid rose without a drive latch");
`endif

endmodule

[tb/sv/adrc_first_order_speed_unit_tb.sv]
// -----------------------------------------------------------------------------
// adrc_first_order_speed_unit_tb: self-checking bench for the ADRC speed unit
// Drives speed samples through the valid/stall input with random gaps, takes
// drive values with random stalls and checks each one against a bit-exact
// fixed-point model of the observer and drive law. Register settings change
// between phases over the APB port, corner values included.
// -----------------------------------------------------------------------------
module adrc_first_order_speed_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_SPARE = 3'd7;   // unmapped slot
	localparam int         IDLE_LIMIT = 600;
	localparam int         HOLD_OFF = 24;
	localparam real        Q24 = 16777216.0;

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [adrc_pkg::ADDR_W-1:0]       paddr;
	logic [adrc_pkg::DATA_W-1:0]       pwdata;
	logic [adrc_pkg::DATA_W-1:0]       prdata;
	logic                              pready;
	logic                              in_valid;
	logic                              in_stall;
	logic signed [adrc_pkg::SIG_W-1:0] speed_meas;
	logic signed [adrc_pkg::SIG_W-1:0] speed_ref;
	logic                              out_valid;
	logic                              out_stall;
	logic signed [adrc_pkg::SIG_W-1:0] drive;

	bit rush;           // no idling on either side
	int idle_cycles;

	class drive_tracker;
		logic        [adrc_pkg::BETA_W-1:0] beta;
		logic        [adrc_pkg::BETA_W-1:0] step_h;
		logic signed [adrc_pkg::SIG_W-1:0]  plant_gain;
		logic signed [adrc_pkg::SIG_W-1:0]  inv_gain;
		logic        [adrc_pkg::GAIN_W-1:0] obs_gain;
		logic        [adrc_pkg::GAIN_W-1:0] ctrl_bw;
		logic        [adrc_pkg::GAIN_W-1:0] limit;
		logic signed [adrc_pkg::SIG_W-1:0]  z_out;
		logic signed [adrc_pkg::SIG_W-1:0]  z_dist;
		logic signed [adrc_pkg::SIG_W-1:0]  u_prev;
		logic signed [adrc_pkg::SIG_W-1:0]  drive_due[$];
		int unsigned                        errors;

		function new();
			beta       = 25'd15099494;
			step_h     = 25'd16777;
			plant_gain = 32'sd16777216;
			inv_gain   = 32'sd16777216;
			obs_gain   = 31'd167772160;
			ctrl_bw    = 31'd167772160;
			limit      = 31'h7FFF_FFFF;
			z_out      = '0;
			z_dist     = '0;
			u_prev     = '0;
			errors     = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				adrc_pkg::REG_BETA:     beta       = value[adrc_pkg::BETA_W-1:0];
				adrc_pkg::REG_STEP_H:   step_h     = value[adrc_pkg::BETA_W-1:0];
				adrc_pkg::REG_PLANT:    plant_gain = value;
				adrc_pkg::REG_INV:      inv_gain   = value;
				adrc_pkg::REG_OBS_GAIN: obs_gain   = value[adrc_pkg::GAIN_W-1:0];
				adrc_pkg::REG_CTRL_BW:  ctrl_bw    = value[adrc_pkg::GAIN_W-1:0];
				adrc_pkg::REG_LIMIT:    limit      = value[adrc_pkg::GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// signal x coefficient, rounded to nearest with ties upward
		function longint qmul(longint a, longint c);
			return (a * c + (longint'(1) <<< (adrc_pkg::FRAC - 1))) >>> adrc_pkg::FRAC;
		endfunction

		function longint sat32(longint x);
			if (x > 64'sh7FFF_FFFF)
				return 64'sh7FFF_FFFF;
			if (x < -64'sh8000_0000)
				return -64'sh8000_0000;
			return x;
		endfunction

		function void note_sample(logic signed [adrc_pkg::SIG_W-1:0] w_in,
		                          logic signed [adrc_pkg::SIG_W-1:0] r_in);
			longint one, w, r, b, h, g, c1, c2, b2, bh, z0, z1, e, gt, y0, y1, v, u, lim;
			one = longint'(1) <<< adrc_pkg::FRAC;
			w   = w_in;
			r   = r_in;
			b   = beta;
			h   = step_h;
			g   = obs_gain;
			c1  = 2 * b - one;
			c2  = 2 * b - 2 * one;
			b2  = qmul(b, b);
			bh  = sat32(qmul(plant_gain, h));

			z0 = sat32(qmul(z_out, c1) + qmul(z_dist, h) - qmul(w, c2) + qmul(u_prev, bh));
			e  = sat32(w - z0);
			gt = qmul(e, g);
			z1 = sat32(z_dist + gt);
			y0 = sat32(qmul(z0, b2) - qmul(w, b2 - one));
			y1 = sat32(z1 + gt);

			v = sat32(r - y0);
			v = sat32(qmul(v, ctrl_bw) - y1);
			u = sat32(qmul(v, inv_gain));
			lim = limit;
			if (u > lim)
				u = lim;
			else if (u < -lim)
				u = -lim;

			z_out  = z0[adrc_pkg::SIG_W-1:0];
			z_dist = z1[adrc_pkg::SIG_W-1:0];
			u_prev = u[adrc_pkg::SIG_W-1:0];
			drive_due.push_back(u[adrc_pkg::SIG_W-1:0]);
		endfunction

		function void check_drive(logic signed [adrc_pkg::SIG_W-1:0] got);
			logic signed [adrc_pkg::SIG_W-1:0] want;
			if (drive_due.size() == 0) begin
				$display("%0t: unexpected drive transfer, expected none, got %0d", $time, got);
				errors++;
			end else begin
				want = drive_due.pop_front();
				if (got !== want) begin
					$display("%0t: drive mismatch, expected %0d, got %0d", $time, want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return drive_due.size();
		endfunction
	endclass

	drive_tracker sb = new();

	adrc_first_order_speed_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.speed_meas (speed_meas),
		.speed_ref  (speed_ref),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.drive      (drive)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// transfer monitor; values seen here are those before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_drive(drive);
			if (in_valid && !in_stall)
				sb.note_sample(speed_meas, speed_ref);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("adrc_first_order_speed_unit_tb: done, errors");
			$finish;
		end
	end

	// drive side: stalls drawn per result, sometimes only once the result shows
	initial begin : drive_sink
		int k;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			k = rush ? 0 : $urandom_range(13, 0);
			if (k > 0) begin
				out_stall <= 1'b1;
				if ($urandom_range(1, 0))
					do @(posedge clk); while (!out_valid);
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic send_sample(input logic signed [31:0] w, input logic signed [31:0] r);
		int gap;
		gap = rush ? 0 : $urandom_range(13, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		speed_meas <= w;
		speed_ref  <= r;
		do @(posedge clk); while (in_stall);
	endtask

	// one edge first so the monitor has noted the last transfer
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic send_corners();
		send_sample(32'sh0000_0000, 32'sh0000_0000);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000, 32'sh8000_0000);
		send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
		send_sample(-32'sd1, 32'sd1);
		send_sample(32'sh0000_0000, 32'sh0000_0000);
		send_sample(32'sh0000_0000, 32'sh0000_0000);
	endtask

	// mostly a speed loosely tracking a stepped reference, some raw noise
	task automatic run_random(input int n);
		int w;
		int r;
		int i;
		w = 0;
		r = 0;
		rush = ($urandom_range(3, 0) == 0);
		for (i = 0; i < n; i++) begin
			if (i == n / 2)
				drain();
			if ($urandom_range(9, 0) < 2) begin
				send_sample($urandom(), $urandom());
			end else begin
				if ($urandom_range(15, 0) == 0)
					r = (int'($urandom_range(400, 0)) - 200) * 65536;
				w = w + ((r - w) >>> 3) + int'($urandom_range(2000, 0)) - 1000;
				send_sample(w, r);
			end
		end
		rush = 1'b0;
		drain();
	endtask

	task automatic program_plausible(input bit wide_limit);
		real bq;
		real hq;
		real gq;
		real bgain;
		logic [31:0] beta_w;
		logic [31:0] h_w;
		logic [31:0] lim_w;
		beta_w = $urandom_range(16777215, 10066330);
		h_w    = $urandom_range(262144, 4096);
		bq     = real'(beta_w) / Q24;
		hq     = real'(h_w) / Q24;
		gq     = (1.0 - bq) * (1.0 - bq) / hq * Q24;
		if (gq > 2147483647.0)
			gq = 2147483647.0;
		bgain = real'($urandom_range(128, 4)) / 16.0;
		if ($urandom_range(1, 0))
			bgain = -bgain;
		lim_w = wide_limit ? $urandom_range(32'h7FFF_FFFF, 32'h1000_0000)
		                   : $urandom_range(100 << 16, 1 << 16);
		apb_write(adrc_pkg::REG_BETA, beta_w);
		apb_write(adrc_pkg::REG_STEP_H, h_w);
		apb_write(adrc_pkg::REG_PLANT, $rtoi(bgain * Q24));
		apb_write(adrc_pkg::REG_INV, $rtoi(Q24 / bgain));
		apb_write(adrc_pkg::REG_OBS_GAIN, $rtoi(gq));
		apb_write(adrc_pkg::REG_CTRL_BW, $urandom_range(60, 1) << adrc_pkg::FRAC);
		apb_write(adrc_pkg::REG_LIMIT, lim_w);
	endtask

	task automatic program_wild();
		apb_write(adrc_pkg::REG_BETA, $urandom());
		apb_write(adrc_pkg::REG_STEP_H, $urandom());
		apb_write(adrc_pkg::REG_PLANT, $urandom());
		apb_write(adrc_pkg::REG_INV, $urandom());
		apb_write(adrc_pkg::REG_OBS_GAIN, $urandom());
		apb_write(adrc_pkg::REG_CTRL_BW, $urandom());
		apb_write(adrc_pkg::REG_LIMIT, $urandom());
	endtask

	initial begin : stimulus
		int p;
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		speed_meas <= '0;
		speed_ref  <= '0;
		idle_cycles <= 0;
		rush = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (HOLD_OFF) @(posedge clk);

		// reset coefficients, small steps then full-scale corners
		send_sample(32'sd65536, 32'sd327680);
		send_sample(32'sd65536, 32'sd327680);
		send_corners();
		run_random(100);

		// every register at its top but inverse gain (bottom), zero clamp, plus the unmapped slot
		apb_write(adrc_pkg::REG_BETA, 32'hFFFF_FFFF);
		apb_write(adrc_pkg::REG_STEP_H, 32'hFFFF_FFFF);
		apb_write(adrc_pkg::REG_PLANT, 32'h7FFF_FFFF);
		apb_write(adrc_pkg::REG_INV, 32'h8000_0000);
		apb_write(adrc_pkg::REG_OBS_GAIN, 32'hFFFF_FFFF);
		apb_write(adrc_pkg::REG_CTRL_BW, 32'hFFFF_FFFF);
		apb_write(adrc_pkg::REG_LIMIT, 32'h0000_0000);
		apb_write(REG_SPARE, 32'h1234_5678);
		send_corners();
		run_random(30);

		// every register at its bottom but inverse gain (top), widest clamp
		apb_write(adrc_pkg::REG_BETA, 32'h0000_0000);
		apb_write(adrc_pkg::REG_STEP_H, 32'h0000_0000);
		apb_write(adrc_pkg::REG_PLANT, 32'h8000_0000);
		apb_write(adrc_pkg::REG_INV, 32'h7FFF_FFFF);
		apb_write(adrc_pkg::REG_OBS_GAIN, 32'h0000_0000);
		apb_write(adrc_pkg::REG_CTRL_BW, 32'h0000_0000);
		apb_write(adrc_pkg::REG_LIMIT, 32'h7FFF_FFFF);
		send_corners();
		run_random(30);

		// unity pole and unity step
		apb_write(adrc_pkg::REG_BETA, 32'h0100_0000);
		apb_write(adrc_pkg::REG_STEP_H, 32'h0100_0000);
		apb_write(adrc_pkg::REG_PLANT, 32'h0100_0000);
		apb_write(adrc_pkg::REG_INV, 32'h0100_0000);
		apb_write(adrc_pkg::REG_OBS_GAIN, 32'h0A00_0000);
		apb_write(adrc_pkg::REG_CTRL_BW, 32'h0A00_0000);
		apb_write(adrc_pkg::REG_LIMIT, 32'h0064_0000);
		run_random(60);

		for (p = 0; p < 6; p++) begin
			case (p % 3)
				0: program_plausible(1'b1);
				1: program_plausible(1'b0);
				default: program_wild();
			endcase
			run_random(120);
		end

		drain();
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("adrc_first_order_speed_unit_tb: done, clean");
		else
			$display("adrc_first_order_speed_unit_tb: done, errors");
		$finish;
	end

endmodule
